// ===== src/mtlb_pkg.sv =====
// ----------------------------------------------------------------------------
// mtlb_pkg
// Types, constants and tag-decode helpers shared by the markup text line
// breaker.
// ----------------------------------------------------------------------------
`default_nettype none

package mtlb_pkg;

  // Fixed point: fraction bits of all sizes (1/16 px)
  localparam int unsigned FracBits = 4;

  // Divider operand widths: scaled size (13b) times glyph width (10b)
  localparam int unsigned DivDividendW = 23;
  localparam int unsigned DivDivisorW  = 10;

  // Reciprocal of ten for 16-bit values, exact with a shift of 19
  localparam logic [15:0] RecipTen   = 16'hCCCD;
  localparam int unsigned RecipShift = 19;

  // Special character codes
  localparam logic [20:0] CodeLt      = 21'd60;
  localparam logic [20:0] CodeGt      = 21'd62;
  localparam logic [20:0] CodeNewline = 21'd10;
  localparam logic [20:0] CodeJpComma = 21'd12289;
  localparam logic [20:0] CodeJpStop  = 21'd12290;

  localparam logic [31:0] ColourWhite = 32'hFFFF_FFFF;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_BASE_SIZE  = 2'd0,
    CFG_LINE_LIMIT = 2'd1,
    CFG_MAX_WIDTH  = 2'd2,
    CFG_MAX_HEIGHT = 2'd3
  } cfg_idx_e;

  typedef enum logic [1:0] {
    SZ_MEDIUM = 2'd0,
    SZ_LARGE  = 2'd1,
    SZ_SMALL  = 2'd2
  } size_sel_e;

  typedef enum logic [2:0] {
    KIND_NONE   = 3'd0,
    KIND_BR     = 3'd1,
    KIND_SL     = 3'd2,
    KIND_SM     = 3'd3,
    KIND_SS     = 3'd4,
    KIND_COLOUR = 3'd5
  } tag_kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SCAN,
    ST_ITEM,
    ST_SCALE,
    ST_MUL,
    ST_DIV,
    ST_CHECK,
    ST_COMMIT,
    ST_DONE
  } state_e;

  typedef struct packed {
    tag_kind_e  kind;
    logic [2:0] colour_sel;
  } tag_info_t;

  typedef struct packed {
    logic [20:0] char_code;
    logic [9:0]  src_width;
    logic [9:0]  src_height;
    logic        final_item;
  } in_beat_t;

  typedef struct packed {
    logic        tag_flag;
    logic        break_flag;
    logic [31:0] rgba_colour;
    logic [15:0] out_width;
    logic [12:0] out_height;
    logic        placed;
    logic [15:0] pos_in_line;
    logic [15:0] line_number;
    logic        run_end;
    logic [19:0] text_width;
    logic [16:0] line_count;
  } out_beat_t;

  // Lower-case fold for ASCII capitals
  function automatic logic [20:0] fold(input logic [20:0] c);
    return (c >= 21'd65 && c <= 21'd90) ? c + 21'd32 : c;
  endfunction

  function automatic logic [31:0] colour_value(input logic [2:0] sel);
    logic [31:0] v;
    case (sel)
      3'd0:    v = 32'hFFFF_FFFF;
      3'd1:    v = 32'hFF00_00FF;
      3'd2:    v = 32'h00FF_00FF;
      3'd3:    v = 32'h0000_FFFF;
      3'd4:    v = 32'h00FF_FFFF;
      3'd5:    v = 32'hFF00_FFFF;
      3'd6:    v = 32'hFFFF_00FF;
      default: v = 32'h0000_00FF;
    endcase
    return v;
  endfunction

  // Letters w r g b c m y k
  function automatic logic [20:0] colour_letter(input logic [2:0] sel);
    logic [20:0] v;
    case (sel)
      3'd0:    v = 21'd119;
      3'd1:    v = 21'd114;
      3'd2:    v = 21'd103;
      3'd3:    v = 21'd98;
      3'd4:    v = 21'd99;
      3'd5:    v = 21'd109;
      3'd6:    v = 21'd121;
      default: v = 21'd107;
    endcase
    return v;
  endfunction

  // Decode the two letters between '<' and '>'
  function automatic tag_info_t tag_kind(input logic [20:0] a_raw, input logic [20:0] b_raw);
    tag_info_t   t;
    logic [20:0] a;
    logic [20:0] b;
    a = fold(a_raw);
    b = fold(b_raw);
    t.kind       = KIND_NONE;
    t.colour_sel = 3'd0;
    if (a == 21'd98 && b == 21'd114) begin
      t.kind = KIND_BR;
    end else if (a == 21'd115) begin
      if (b == 21'd108) t.kind = KIND_SL;
      else if (b == 21'd109) t.kind = KIND_SM;
      else if (b == 21'd115) t.kind = KIND_SS;
    end else if (a == 21'd99) begin
      for (int k = 7; k >= 0; k--) begin
        if (b == colour_letter(3'(k))) begin
          t.kind       = KIND_COLOUR;
          t.colour_sel = 3'(k);
        end
      end
    end
    return t;
  endfunction

endpackage

`default_nettype wire

// ===== src/mtlb_div.sv =====
// ----------------------------------------------------------------------------
// mtlb_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mtlb_div
  import mtlb_pkg::*;
#(
  parameter int unsigned DividendW = DivDividendW,
  parameter int unsigned DivisorW  = DivDivisorW
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 start_i,
  input  wire logic [DividendW-1:0] dividend_i,
  input  wire logic [DivisorW-1:0]  divisor_i,
  output logic                      done_o,
  output logic [DividendW-1:0]      quotient_o
);

  localparam int unsigned CntW = $clog2(DividendW + 1);

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [CntW-1:0]      cnt_q, cnt_d;
  logic [DividendW-1:0] dq_q, dq_d;
  logic [DivisorW-1:0]  rem_q, rem_d;
  logic [DivisorW-1:0]  dvs_q, dvs_d;
  logic [DivisorW:0]    trial;

  assign trial = {rem_q, dq_q[DividendW-1]};

  // One shift-subtract step a cycle
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dq_d   = dq_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(DividendW);
      dq_d   = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DivisorW'(trial - {1'b0, dvs_q});
        dq_d  = {dq_q[DividendW-2:0], 1'b1};
      end else begin
        rem_d = trial[DivisorW-1:0];
        dq_d  = {dq_q[DividendW-2:0], 1'b0};
      end
      cnt_d = cnt_q - 1'b1;
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o     = done_q;
  assign quotient_o = dq_q;

endmodule

`default_nettype wire

// ===== src/markup_text_line_breaker_core.sv =====
// Results: a glyph's width comes from the 23-step divider (width = size*w/h);
//   newlines and tags skip the divider.
// Flow: a new input beat is taken only after all results of the previous one
//   are released, 0 to 4 results a beat; output stalls hold the sequencer.
// Reset: asynchronous, active low; clears layout state, sets base_size 160,
//   the other registers 0 and the colour to white. Layout state also
//   returns to reset after the beat marked final_item.
// ----------------------------------------------------------------------------
// markup_text_line_breaker_core
// Markup tag detection and greedy line placement of glyph beats.
// ----------------------------------------------------------------------------
`default_nettype none

module markup_text_line_breaker_core
  import mtlb_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_beat_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire cfg_idx_e  cfg_index_i,
  input  wire logic [11:0] cfg_data_i
);

  // Configuration registers
  logic [11:0] base_q;
  logic [7:0]  ll_q;
  logic [11:0] mw_q;
  logic [11:0] mh_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_q <= 12'd160;
      ll_q   <= '0;
      mw_q   <= '0;
      mh_q   <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CFG_BASE_SIZE:  base_q <= cfg_data_i;
        CFG_LINE_LIMIT: ll_q   <= cfg_data_i[7:0];
        CFG_MAX_WIDTH:  mw_q   <= cfg_data_i;
        CFG_MAX_HEIGHT: mh_q   <= cfg_data_i;
        default:        base_q <= base_q;
      endcase
    end
  end

  // Window of pending beats (the newest beat goes into the first free slot)
  logic [20:0] code_q [4];
  logic [9:0]  sw_q   [4];
  logic [9:0]  sh_q   [4];
  logic [20:0] code_d [4];
  logic [9:0]  sw_d   [4];
  logic [9:0]  sh_d   [4];

  state_e      state_q, state_d;
  logic [2:0]  n_q, n_d;
  logic [2:0]  head_q, head_d;
  logic        final_q, final_d;
  logic [1:0]  j_q, j_d;
  logic        grp_tag_q, grp_tag_d;
  logic        grp_br_q, grp_br_d;
  size_sel_e   size_q, size_d;
  logic [31:0] colour_q, colour_d;
  logic [19:0] rw_q, rw_d;
  logic [15:0] gp_q, gp_d;
  logic [15:0] cl_q, cl_d;
  logic [19:0] wl_q, wl_d;
  logic        trunc_q, trunc_d;
  logic [15:0] num_q, num_d;
  logic [12:0] h_q, h_d;
  logic [15:0] w_q, w_d;
  logic        brk_q, brk_d;
  logic        tlim_q, tlim_d;
  logic [28:0] hprod_q, hprod_d;
  logic        out_valid_q, out_valid_d;
  out_beat_t   out_q, out_d;

  // Divider hookup
  logic                    div_start;
  logic [DivDividendW-1:0] div_quot;
  logic                    div_done;
  logic [9:0]              divisor;

  // Current item of the group
  logic [1:0]  idx;
  logic [20:0] cur_code;
  logic [9:0]  cur_sw;
  logic [9:0]  cur_sh;
  logic        cur_tag;
  logic        cur_brk;

  assign idx      = 2'(head_q + {1'b0, j_q});
  assign cur_code = code_q[idx];
  assign cur_sw   = sw_q[idx];
  assign cur_sh   = sh_q[idx];
  assign cur_tag  = grp_tag_q | (cur_code == CodeNewline);
  assign cur_brk  = grp_tag_q ? (grp_br_q && j_q == 2'd0) : (cur_code == CodeNewline);
  assign divisor  = (cur_sh == 10'd0) ? 10'd1 : cur_sh;

  mtlb_div #(
    .DividendW (DivDividendW),
    .DivisorW  (DivDivisorW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (DivDividendW'(h_q) * DivDividendW'(cur_sw)),
    .divisor_i  (divisor),
    .done_o     (div_done),
    .quotient_o (div_quot)
  );

  // Scratch for the sequencer
  tag_info_t   tinfo;
  logic [2:0]  avail;
  logic [31:0] recip_prod;
  logic [20:0] wsum;
  logic [16:0] lines_next;
  logic        last_res;
  logic        last_in_grp;
  logic        cut;
  logic [20:0] psum;

  assign avail      = n_q - head_q;
  assign recip_prod = 32'(num_q) * 32'(RecipTen);
  assign wsum       = 21'(rw_q) + 21'(w_q);
  assign lines_next = 17'(cl_q) + 17'd2;

  // Sequencer and datapath
  always_comb begin
    state_d     = state_q;
    code_d      = code_q;
    sw_d        = sw_q;
    sh_d        = sh_q;
    n_d         = n_q;
    head_d      = head_q;
    final_d     = final_q;
    j_d         = j_q;
    grp_tag_d   = grp_tag_q;
    grp_br_d    = grp_br_q;
    size_d      = size_q;
    colour_d    = colour_q;
    rw_d        = rw_q;
    gp_d        = gp_q;
    cl_d        = cl_q;
    wl_d        = wl_q;
    trunc_d     = trunc_q;
    num_d       = num_q;
    h_d         = h_q;
    w_d         = w_q;
    brk_d       = brk_q;
    tlim_d      = tlim_q;
    hprod_d     = hprod_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_d       = out_q;
    div_start   = 1'b0;
    in_ready_o  = 1'b0;
    tinfo       = tag_kind(code_q[1], code_q[2]);
    last_res    = final_q && ({1'b0, idx} == n_q - 3'd1);
    last_in_grp = grp_tag_q ? (j_q == 2'd3) : 1'b1;
    cut         = 1'b0;
    psum        = '0;

    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          code_d[n_q[1:0]] = in_data_i.char_code;
          sw_d[n_q[1:0]]   = in_data_i.src_width;
          sh_d[n_q[1:0]]   = in_data_i.src_height;
          n_d              = n_q + 3'd1;
          head_d           = '0;
          final_d          = in_data_i.final_item;
          state_d          = ST_SCAN;
        end
      end

      // Pick the next group: a whole tag or a single item, else finish the beat
      ST_SCAN: begin
        j_d = '0;
        if (n_q > head_q && (avail == 3'd4 || final_q)) begin
          state_d   = ST_ITEM;
          grp_tag_d = 1'b0;
          grp_br_d  = 1'b0;
          if (avail == 3'd4 && code_q[0] == CodeLt && code_q[3] == CodeGt &&
              tinfo.kind != KIND_NONE) begin
            grp_tag_d = 1'b1;
            grp_br_d  = (tinfo.kind == KIND_BR);
            case (tinfo.kind)
              KIND_SL:     size_d   = SZ_LARGE;
              KIND_SM:     size_d   = SZ_MEDIUM;
              KIND_SS:     size_d   = SZ_SMALL;
              KIND_COLOUR: colour_d = colour_value(tinfo.colour_sel);
              default:     size_d   = size_q;
            endcase
          end
        end else begin
          state_d = ST_DONE;
        end
      end

      // Size numerator: base*14+5 or base*7+5; tags and newlines skip to the check
      ST_ITEM: begin
        if (cur_tag) begin
          w_d     = '0;
          h_d     = '0;
          state_d = ST_CHECK;
        end else begin
          if (size_q == SZ_LARGE) begin
            num_d = (16'(base_q) << 4) - (16'(base_q) << 1) + 16'd5;
          end else begin
            num_d = (16'(base_q) << 3) - 16'(base_q) + 16'd5;
          end
          state_d = ST_SCALE;
        end
      end

      ST_SCALE: begin
        if (size_q == SZ_MEDIUM) h_d = 13'(base_q);
        else                     h_d = recip_prod[RecipShift +: 13];
        state_d = ST_MUL;
      end

      ST_MUL: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end

      ST_DIV: begin
        if (div_done) begin
          w_d     = (|div_quot[DivDividendW-1:16]) ? 16'hFFFF : div_quot[15:0];
          state_d = ST_CHECK;
        end
      end

      // Wrap test and limit checks
      ST_CHECK: begin
        brk_d = cur_brk ||
                (gp_q != 16'd0 && mw_q != 12'd0 &&
                 wsum > (21'(mw_q) << FracBits) &&
                 !(cur_code == CodeJpComma || cur_code == CodeJpStop));
        tlim_d  = (ll_q != 8'd0) && (lines_next > 17'(ll_q));
        hprod_d = 29'(lines_next) * 29'(base_q);
        state_d = ST_COMMIT;
      end

      // Update layout state and emit one result beat
      ST_COMMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d             = '0;
          out_d.tag_flag    = cur_tag;
          out_d.break_flag  = cur_brk;
          out_d.rgba_colour = colour_q;
          out_d.out_width   = w_q;
          out_d.out_height  = h_q;
          if (!trunc_q) begin
            cut = brk_q && (tlim_q ||
                  (mh_q != 12'd0 && hprod_q > (29'(mh_q) << FracBits)));
            if (cut) begin
              trunc_d = 1'b1;
            end else begin
              if (brk_q) begin
                if (wl_d < rw_d) wl_d = rw_d;
                rw_d = '0;
                gp_d = '0;
                if (cl_d != 16'hFFFF) cl_d = cl_d + 16'd1;
              end
              if (!cur_tag) begin
                out_d.placed      = 1'b1;
                out_d.pos_in_line = gp_d;
                out_d.line_number = cl_d;
                psum = 21'(rw_d) + 21'(w_q);
                rw_d = psum[20] ? 20'hFFFFF : psum[19:0];
                if (gp_d != 16'hFFFF) gp_d = gp_d + 16'd1;
              end
            end
          end
          if (last_res) begin
            out_d.run_end    = 1'b1;
            out_d.text_width = (wl_d < rw_d) ? rw_d : wl_d;
            out_d.line_count = 17'(cl_d) + 17'd1;
          end
          out_valid_d = 1'b1;
          if (last_in_grp) begin
            head_d  = head_q + (grp_tag_q ? 3'd4 : 3'd1);
            state_d = ST_SCAN;
          end else begin
            j_d     = j_q + 2'd1;
            state_d = ST_ITEM;
          end
        end
      end

      // Clear after the final beat, else slide the window
      ST_DONE: begin
        if (final_q) begin
          n_d      = '0;
          size_d   = SZ_MEDIUM;
          colour_d = ColourWhite;
          rw_d     = '0;
          gp_d     = '0;
          cl_d     = '0;
          wl_d     = '0;
          trunc_d  = 1'b0;
        end else begin
          for (int k = 0; k < 3; k++) begin
            code_d[k] = code_q[2'(k) + head_q[1:0]];
            sw_d[k]   = sw_q[2'(k) + head_q[1:0]];
            sh_d[k]   = sh_q[2'(k) + head_q[1:0]];
          end
          n_d = avail;
        end
        head_d  = '0;
        final_d = 1'b0;
        state_d = ST_IDLE;
      end

      default: state_d = ST_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else         state_q <= state_d;
  end

  // Control and layout state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q         <= '0;
      head_q      <= '0;
      final_q     <= 1'b0;
      j_q         <= '0;
      grp_tag_q   <= 1'b0;
      grp_br_q    <= 1'b0;
      size_q      <= SZ_MEDIUM;
      colour_q    <= ColourWhite;
      rw_q        <= '0;
      gp_q        <= '0;
      cl_q        <= '0;
      wl_q        <= '0;
      trunc_q     <= 1'b0;
      brk_q       <= 1'b0;
      tlim_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      n_q         <= n_d;
      head_q      <= head_d;
      final_q     <= final_d;
      j_q         <= j_d;
      grp_tag_q   <= grp_tag_d;
      grp_br_q    <= grp_br_d;
      size_q      <= size_d;
      colour_q    <= colour_d;
      rw_q        <= rw_d;
      gp_q        <= gp_d;
      cl_q        <= cl_d;
      wl_q        <= wl_d;
      trunc_q     <= trunc_d;
      brk_q       <= brk_d;
      tlim_q      <= tlim_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    code_q  <= code_d;
    sw_q    <= sw_d;
    sh_q    <= sh_d;
    num_q   <= num_d;
    h_q     <= h_d;
    w_q     <= w_d;
    hprod_q <= hprod_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// ===== tb/sv/markup_text_line_breaker_core_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// markup_text_line_breaker_core_test
// Self-checking bench: drives glyph beats with markup tags, newlines and
// wrap cases through several register settings, predicts every result beat
// in-bench and compares each output beat field by field in order.
// ----------------------------------------------------------------------------

module markup_text_line_breaker_core_test;
  import mtlb_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic      clk_i = 1'b0;
  logic      rst_ni = 1'b0;
  logic      in_valid_i = 1'b0;
  logic      in_ready_o;
  in_beat_t  in_data_i = '0;
  logic      out_valid_o;
  logic      out_ready_i = 1'b0;
  out_beat_t out_data_o;
  logic      cfg_valid_i = 1'b0;
  logic      cfg_ready_o;
  cfg_idx_e  cfg_index_i = CFG_BASE_SIZE;
  logic [11:0] cfg_data_i = '0;

  markup_text_line_breaker_core dut (.*);

  always #5 clk_i = ~clk_i;

  // Layout model state
  logic [11:0] base_r;
  logic [7:0]  line_lim_r;
  logic [11:0] width_lim_r;
  logic [11:0] height_lim_r;
  logic [20:0] win_code [3];
  logic [19:0] win_dim  [3];
  int unsigned win_n;
  size_sel_e   size_sel;
  logic [31:0] colour;
  logic [19:0] run_w;
  logic [15:0] gpos;
  logic [15:0] cur_line;
  logic [19:0] widest;
  bit          trunc;

  out_beat_t layout_q[$];
  int  errors = 0;
  bit  no_idle = 0;
  int  quiet_cycles = 0;

  function automatic logic [20:0] lower(logic [20:0] c);
    return (c >= 21'd65 && c <= 21'd90) ? c + 21'd32 : c;
  endfunction

  function automatic logic [31:0] tag_colour(int k);
    case (k)
      0: return 32'hFFFF_FFFF;
      1: return 32'hFF00_00FF;
      2: return 32'h00FF_00FF;
      3: return 32'h0000_FFFF;
      4: return 32'h00FF_FFFF;
      5: return 32'hFF00_FFFF;
      6: return 32'hFFFF_00FF;
      default: return 32'h0000_00FF;
    endcase
  endfunction

  // Decode "<ab>" letters; sets sel for colour tags
  function automatic tag_kind_e decode_tag(logic [20:0] a_in, logic [20:0] b_in,
                                           output int sel);
    logic [20:0] a;
    logic [20:0] b;
    string letters;
    a = lower(a_in);
    b = lower(b_in);
    letters = "wrgbcmyk";
    sel = 0;
    if (a == 21'd98 && b == 21'd114) return KIND_BR;
    if (a == 21'd115) begin
      if (b == 21'd108) return KIND_SL;
      if (b == 21'd109) return KIND_SM;
      if (b == 21'd115) return KIND_SS;
      return KIND_NONE;
    end
    if (a == 21'd99)
      for (int k = 0; k < 8; k++)
        if (b == 21'(letters[k])) begin
          sel = k;
          return KIND_COLOUR;
        end
    return KIND_NONE;
  endfunction

  function automatic longint glyph_size();
    longint b;
    b = base_r;
    if (size_sel == SZ_LARGE) return (b * 14 + 5) / 10;
    if (size_sel == SZ_SMALL) return (b * 7 + 5) / 10;
    return b;
  endfunction

  task automatic clear_layout();
    win_n = 0;
    size_sel = SZ_MEDIUM;
    colour = 32'hFFFF_FFFF;
    run_w = '0;
    gpos = '0;
    cur_line = '0;
    widest = '0;
    trunc = 0;
  endtask

  // Place one item and queue its result beat
  task automatic place_item(logic [20:0] code, logic [19:0] dim, bit is_tag, bit is_brk);
    out_beat_t r;
    longint w, h, sw, sh, nxt, lines_next;
    bit brk;
    r = '0;
    w = 0;
    brk = is_brk;
    r.tag_flag = is_tag;
    r.break_flag = is_brk;
    r.rgba_colour = colour;
    if (!is_tag) begin
      sw = dim[9:0];
      sh = dim[19:10];
      if (sh == 0) sh = 1;
      h = glyph_size() & 'h1FFF;
      w = h * sw / sh;
      if (w > 65535) w = 65535;
      r.out_width = w[15:0];
      r.out_height = h[12:0];
    end
    if (!trunc) begin
      if (!brk && gpos > 0 && width_lim_r > 0) begin
        nxt = longint'(run_w) + w;
        if (nxt > (longint'(width_lim_r) << 4) && code != CodeJpComma && code != CodeJpStop)
          brk = 1;
      end
      if (brk) begin
        lines_next = longint'(cur_line) + 2;
        if ((line_lim_r > 0 && lines_next > line_lim_r) ||
            (height_lim_r > 0 && lines_next * base_r > (longint'(height_lim_r) << 4)))
          trunc = 1;
        else begin
          if (widest < run_w) widest = run_w;
          run_w = '0;
          gpos = '0;
          if (cur_line != 16'hFFFF) cur_line++;
        end
      end
      if (!trunc && !is_tag) begin
        nxt = longint'(run_w) + w;
        r.placed = 1'b1;
        r.pos_in_line = gpos;
        r.line_number = cur_line;
        run_w = (nxt > 1048575) ? 20'hFFFFF : nxt[19:0];
        if (gpos != 16'hFFFF) gpos++;
      end
    end
    layout_q.push_back(r);
  endtask

  // Run one accepted input beat through the window and layout
  task automatic predict_beat(in_beat_t b);
    logic [20:0] codes [4];
    logic [19:0] dims [4];
    int unsigned n, head;
    int sel;
    tag_kind_e kind;
    bit nl;
    out_beat_t last;
    n = win_n;
    head = 0;
    for (int j = 0; j < n; j++) begin
      codes[j] = win_code[j];
      dims[j] = win_dim[j];
    end
    codes[n] = b.char_code;
    dims[n] = {b.src_height, b.src_width};
    n++;
    while (n > head && (n - head == 4 || b.final_item)) begin
      kind = KIND_NONE;
      if (codes[head] == CodeLt && n - head >= 4 && codes[head+3] == CodeGt)
        kind = decode_tag(codes[head+1], codes[head+2], sel);
      if (kind != KIND_NONE) begin
        case (kind)
          KIND_SL: size_sel = SZ_LARGE;
          KIND_SM: size_sel = SZ_MEDIUM;
          KIND_SS: size_sel = SZ_SMALL;
          KIND_COLOUR: colour = tag_colour(sel);
          default: ;
        endcase
        for (int j = 0; j < 4; j++)
          place_item(codes[head+j], dims[head+j], 1, kind == KIND_BR && j == 0);
        head += 4;
      end else begin
        nl = codes[head] == CodeNewline;
        place_item(codes[head], dims[head], nl, nl);
        head++;
      end
    end
    if (b.final_item) begin
      last = layout_q.pop_back();
      last.run_end = 1'b1;
      last.text_width = (widest < run_w) ? run_w : widest;
      last.line_count = 17'(cur_line) + 17'd1;
      layout_q.push_back(last);
      clear_layout();
    end else begin
      win_n = n - head;
      for (int j = 0; j < win_n; j++) begin
        win_code[j] = codes[head+j];
        win_dim[j] = dims[head+j];
      end
    end
  endtask

  task automatic idle_burst();
    if (!no_idle && $urandom_range(3) == 0) repeat ($urandom_range(6, 1)) @(negedge clk_i);
  endtask

  // Send one glyph beat and wait for acceptance
  task automatic send_glyph(logic [20:0] code, logic [9:0] w, logic [9:0] h, bit fin);
    idle_burst();
    in_data_i <= {code, w, h, fin};
    in_valid_i <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
    predict_beat(in_data_i);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic send_text(string s, bit fin);
    for (int i = 0; i < s.len(); i++)
      send_glyph(21'(s[i]), 10'($urandom_range(1, 40)), 10'($urandom_range(1, 40)),
                 fin && i == s.len() - 1);
  endtask

  task automatic wait_drained();
    while (layout_q.size() != 0) @(negedge clk_i);
    repeat (40) @(negedge clk_i);
  endtask

  task automatic write_reg(cfg_idx_e idx, logic [11:0] val);
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_BASE_SIZE:  base_r = val;
      CFG_LINE_LIMIT: line_lim_r = val[7:0];
      CFG_MAX_WIDTH:  width_lim_r = val;
      default:        height_lim_r = val;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_layout(logic [11:0] bs, logic [7:0] ll, logic [11:0] mw, logic [11:0] mh);
    wait_drained();
    write_reg(CFG_BASE_SIZE, bs);
    write_reg(CFG_LINE_LIMIT, 12'(ll));
    write_reg(CFG_MAX_WIDTH, mw);
    write_reg(CFG_MAX_HEIGHT, mh);
  endtask

  // Tags, case folding, newline, unfinished tags, field extremes
  task automatic test_directed();
    send_text("<SL>ab<cR>c<ss>\n<bR>d<cx>e<sm>", 0);
    send_glyph(21'h1FFFFF, 10'h3FF, 10'h3FF, 0);
    send_glyph(21'd0, 10'd0, 10'd0, 0);
    send_glyph(CodeJpComma, 10'h3FF, 10'd1, 0);
    send_text("<c", 1);
  endtask

  // Wrap, Japanese punctuation exemption, line and height truncation
  task automatic test_wrapping();
    set_layout(12'd160, 8'd3, 12'd40, 12'd0);
    send_text("abc", 0);
    send_glyph(CodeJpStop, 10'd30, 10'd10, 0);
    send_glyph(CodeJpComma, 10'd30, 10'd10, 0);
    send_text("defgh\nij<br>kl", 1);
    set_layout(12'd4095, 8'd255, 12'd4095, 12'd30);
    send_text("x\ny\nz", 1);
    set_layout(12'd1, 8'd0, 12'd1, 12'd4095);
    send_text("<sl>mn<ss>op", 1);
  endtask

  // Random texts: mostly well-formed tags with random letters and glyphs
  task automatic test_random(int items);
    string tags [12];
    string t;
    logic [20:0] code;
    int left;
    tags = '{"br", "sl", "sm", "ss", "cw", "cr", "cg", "cb", "cc", "cm", "cy", "ck"};
    left = items;
    while (left > 0) begin
      case ($urandom_range(9))
        0, 1, 2: begin
          t = tags[$urandom_range(11)];
          if ($urandom_range(1)) t = t.toupper();
          send_text({"<", t, ">"}, 0);
          left -= 4;
        end
        3: begin
          send_glyph(CodeNewline, 10'($urandom_range(1023)), 10'($urandom_range(1, 1023)), 0);
          left--;
        end
        4: begin
          send_text("<q", 0);
          left -= 2;
        end
        default: begin
          case ($urandom_range(3))
            0: code = 21'($urandom_range(1114111));
            1: code = CodeJpComma + 21'($urandom_range(1));
            default: code = 21'($urandom_range(126, 32));
          endcase
          send_glyph(code, 10'($urandom_range(1023)), 10'($urandom_range(1023)), 0);
          left--;
        end
      endcase
      if ($urandom_range(15) == 0) begin
        send_glyph(21'd97, 10'($urandom_range(60)), 10'($urandom_range(1, 60)), 1);
        left--;
      end
    end
    send_glyph(21'd98, 10'd8, 10'd8, 1);
  endtask

  // Output check, with random stall bursts
  always @(posedge clk_i) begin
    out_beat_t e;
    if (out_valid_o && out_ready_i) begin
      if (layout_q.size() == 0) begin
        $error("unexpected result beat %p", out_data_o);
        errors++;
      end else begin
        e = layout_q.pop_front();
        if (out_data_o.tag_flag !== e.tag_flag) begin
          $error("tag_flag exp %0d got %0d", e.tag_flag, out_data_o.tag_flag); errors++; end
        if (out_data_o.break_flag !== e.break_flag) begin
          $error("break_flag exp %0d got %0d", e.break_flag, out_data_o.break_flag); errors++; end
        if (out_data_o.rgba_colour !== e.rgba_colour) begin
          $error("rgba_colour exp %h got %h", e.rgba_colour, out_data_o.rgba_colour); errors++; end
        if (out_data_o.out_width !== e.out_width) begin
          $error("out_width exp %0d got %0d", e.out_width, out_data_o.out_width); errors++; end
        if (out_data_o.out_height !== e.out_height) begin
          $error("out_height exp %0d got %0d", e.out_height, out_data_o.out_height); errors++; end
        if (out_data_o.placed !== e.placed) begin
          $error("placed exp %0d got %0d", e.placed, out_data_o.placed); errors++; end
        if (out_data_o.pos_in_line !== e.pos_in_line) begin
          $error("pos_in_line exp %0d got %0d", e.pos_in_line, out_data_o.pos_in_line); errors++; end
        if (out_data_o.line_number !== e.line_number) begin
          $error("line_number exp %0d got %0d", e.line_number, out_data_o.line_number); errors++; end
        if (out_data_o.run_end !== e.run_end) begin
          $error("run_end exp %0d got %0d", e.run_end, out_data_o.run_end); errors++; end
        if (out_data_o.text_width !== e.text_width) begin
          $error("text_width exp %0d got %0d", e.text_width, out_data_o.text_width); errors++; end
        if (out_data_o.line_count !== e.line_count) begin
          $error("line_count exp %0d got %0d", e.line_count, out_data_o.line_count); errors++; end
      end
    end
  end

  initial begin
    forever begin
      @(negedge clk_i);
      if (!no_idle && $urandom_range(5) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(6, 1)) @(negedge clk_i);
      end
      out_ready_i <= 1'b1;
    end
  end

  // Watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchdogLimit) begin
      $display("[markup_text_line_breaker_core] ERROR");
      $finish;
    end
  end

  initial begin
    base_r = 12'd160;
    line_lim_r = '0;
    width_lim_r = '0;
    height_lim_r = '0;
    clear_layout();
    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;
    test_directed();
    test_wrapping();
    set_layout(12'd200, 8'd0, 12'd120, 12'd0);
    test_random(80);
    set_layout(12'd90, 8'd6, 12'd60, 12'd80);
    test_random(40);
    set_layout(12'd160, 8'd0, 12'd0, 12'd0);
    no_idle = 1;
    test_random(30);
    wait_drained();
    if (errors == 0) $display("[markup_text_line_breaker_core] OK");
    else $display("[markup_text_line_breaker_core] ERROR");
    $finish;
  end

endmodule
